[rtl/dwcb_pkg.sv]
package dwcb_pkg;

  localparam int MAX_DIMS    = 6;
  localparam int MAX_MER_LEN = 6;
  localparam int DIST_BITS   = 16;
  localparam int NUM_BOUNDS  = MAX_DIMS - 1;
  localparam int MAX_CELLS   = 1 << MAX_MER_LEN;

  localparam int POS_BITS   = $clog2(MAX_MER_LEN);
  localparam int CNT_BITS   = $clog2(MAX_MER_LEN + 1);
  localparam int KIDX_BITS  = $clog2(MAX_CELLS);
  localparam int CELL_BITS  = 16;

  // configuration register indexes
  localparam logic [2:0] REG_DIM_COUNT  = 3'd0;
  localparam logic [2:0] REG_MER_LENGTH = 3'd1;
  localparam logic [2:0] REG_BOUND_0    = 3'd2;
  localparam logic [2:0] REG_BOUND_LAST = 3'd6;

  localparam logic [2:0] DIM_RESET = 3'd4;
  localparam logic [2:0] LEN_RESET = 3'd3;

  typedef logic [NUM_BOUNDS-1:0][DIST_BITS-1:0] bound_arr_t;

  // digit of a distance: last cell at or above the top bound, else first bound at or above it
  function automatic logic [2:0] quantize(input logic [DIST_BITS-1:0] v,
                                          input logic [2:0] d,
                                          input bound_arr_t b);
    logic [2:0] top;
    logic [2:0] g;
    top = d - 3'd2;
    g = top;
    for (int k = NUM_BOUNDS - 2; k >= 0; k--) begin
      if (3'(k) < top && b[k] >= v) begin
        g = 3'(k);
      end
    end
    if (v >= b[top]) begin
      g = d - 3'd1;
    end
    return g;
  endfunction

endpackage

[rtl/dmer_window_cell_binning.sv]
// D-mer window cell binning.
// Input channel (in_valid / in_stall): one word per distance with its deviation
// and a read_start flag. A word is taken when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall): cell words, the window's own cell first
// (is_primary), then its neighbour cells; last marks the final cell of an input.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): dim_count,
// mer_length and bound_0..bound_4 at indexes 0..6; cfg_ready is always high and
// writes are meant for an idle block.
// Timing: the block takes one input word, then walks the window one position
// a cycle through one quantizer and one multiply-add unit over the L positions,
// then sends 2^n cells one a cycle while out_stall is low, n being the number
// of positions that reach the next cell. An input that does not yet fill the
// window gives no cell and leaves the block ready for the next input.
// A stalled output holds its word and the block takes no input until the last
// cell of the current input has gone.
// Reset sets dim_count 4, mer_length 3, all bounds 0 and starts a new read.
module dmer_window_cell_binning
  import dwcb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DIST_BITS-1:0] distance,
  input  logic [DIST_BITS-1:0] deviation,
  input  logic                 read_start,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CELL_BITS-1:0] cell_index,
  output logic                 is_primary,
  output logic [15:0]          window_start,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  typedef enum logic [1:0] {IDLE, PROC, EMIT} state_t;

  state_t state;

  logic [2:0]  dim_count;
  logic [2:0]  mer_length;
  bound_arr_t  bounds;

  logic [DIST_BITS-1:0] dist_win [MAX_MER_LEN];
  logic [DIST_BITS-1:0] dev_win  [MAX_MER_LEN];
  logic [15:0]          read_count;

  logic [POS_BITS-1:0]  idx;
  logic [CELL_BITS-1:0] weight;
  logic [CELL_BITS-1:0] cell_sum;
  logic [CELL_BITS-1:0] wlist [MAX_MER_LEN];
  logic [CNT_BITS-1:0]  nraise;
  logic [KIDX_BITS-1:0] k;

  logic [2:0]           d_eff;
  logic [2:0]           l_eff;
  logic [POS_BITS-1:0]  base;
  logic                 in_acc;
  logic                 out_acc;
  logic [15:0]          cnt_base;
  logic [15:0]          cnt_next;
  logic [DIST_BITS-1:0] v;
  logic [DIST_BITS:0]   reach;
  logic [2:0]           g;
  logic                 raise;
  logic [CELL_BITS-1:0] cell_next;
  logic [CNT_BITS-1:0]  nraise_next;
  logic [KIDX_BITS-1:0] k_next;
  logic [KIDX_BITS-1:0] k_mask;
  logic [CELL_BITS-1:0] offset;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != IDLE);
  assign out_valid = (state == EMIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    d_eff = dim_count;
    if (dim_count < 3'd2) d_eff = 3'd2;
    if (dim_count > 3'(MAX_DIMS)) d_eff = 3'(MAX_DIMS);
    l_eff = mer_length;
    if (mer_length < 3'd1) l_eff = 3'd1;
    if (mer_length > 3'(MAX_MER_LEN)) l_eff = 3'(MAX_MER_LEN);
    base = POS_BITS'(3'(MAX_MER_LEN) - l_eff);

    cnt_base = read_start ? 16'd0 : read_count;
    cnt_next = (cnt_base == 16'hFFFF) ? cnt_base : cnt_base + 16'd1;

    // one window position per cycle, newest first
    v         = dist_win[idx];
    reach     = {1'b0, v} + {1'b0, dev_win[idx]};
    g         = quantize(v, d_eff, bounds);
    raise     = (g < d_eff - 3'd2) && (reach > {1'b0, bounds[g]});
    cell_next = cell_sum + CELL_BITS'(g * weight);
    nraise_next = raise ? nraise + CNT_BITS'(1) : nraise;

    k_next = k + KIDX_BITS'(1);
    k_mask = KIDX_BITS'(((KIDX_BITS+1)'(1) << nraise) - (KIDX_BITS+1)'(1));
    offset = '0;
    for (int b = 0; b < MAX_MER_LEN; b++) begin
      if (k_next[b]) offset = offset + wlist[b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count  <= DIM_RESET;
      mer_length <= LEN_RESET;
      bounds     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DIM_COUNT:  dim_count  <= cfg_data[2:0];
        REG_MER_LENGTH: mer_length <= cfg_data[2:0];
        default: begin
          if (cfg_index >= REG_BOUND_0 && cfg_index <= REG_BOUND_LAST) begin
            bounds[cfg_index - REG_BOUND_0] <= cfg_data[DIST_BITS-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      read_count <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_acc) begin
            for (int i = 0; i < MAX_MER_LEN - 1; i++) begin
              dist_win[i] <= dist_win[i+1];
              dev_win[i]  <= dev_win[i+1];
            end
            dist_win[MAX_MER_LEN-1] <= distance;
            dev_win[MAX_MER_LEN-1]  <= deviation;
            read_count   <= cnt_next;
            window_start <= cnt_next - 16'(l_eff);
            idx          <= POS_BITS'(MAX_MER_LEN - 1);
            weight       <= CELL_BITS'(1);
            cell_sum     <= '0;
            nraise       <= '0;
            if (cnt_next >= 16'(l_eff)) begin
              state <= PROC;
            end
          end
        end
        PROC: begin
          cell_sum <= cell_next;
          weight   <= CELL_BITS'(weight * d_eff);
          nraise   <= nraise_next;
          idx      <= idx - POS_BITS'(1);
          if (raise) begin
            wlist[0] <= weight;
            for (int i = 1; i < MAX_MER_LEN; i++) begin
              wlist[i] <= wlist[i-1];
            end
          end
          if (idx == base) begin
            state      <= EMIT;
            k          <= '0;
            cell_index <= cell_next;
            is_primary <= 1'b1;
            last       <= (nraise_next == '0);
          end
        end
        EMIT: begin
          if (out_acc) begin
            if (last) begin
              state <= IDLE;
            end else begin
              k          <= k_next;
              cell_index <= cell_sum + offset;
              is_primary <= 1'b0;
              last       <= (k_next == k_mask);
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_no_input_while_sending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while cells are pending");

  a_neighbour_after_primary: assert property (@(posedge clk) disable iff (rst)
    out_acc && is_primary && !last |=> out_valid && !is_primary)
    else $error("neighbour cell missing after primary cell");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    out_acc && last |=> !out_valid && !in_stall)
    else $error("block not idle after last cell");

  a_first_is_primary: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> is_primary)
    else $error("first cell of an input not marked primary");

endmodule

[tb/sv/dmer_window_cell_binning_checker.sv]
`timescale 1ns / 100ps

module dmer_window_cell_binning_checker
  import dwcb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [DIST_BITS-1:0] distance,
  input  logic [DIST_BITS-1:0] deviation,
  input  logic                 read_start,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [CELL_BITS-1:0] cell_index,
  input  logic                 is_primary,
  input  logic [15:0]          window_start,
  input  logic                 last,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct {
    logic [CELL_BITS-1:0] cell_no;
    logic                 primary;
    logic [15:0]          wstart;
    logic                 last;
  } cell_word_t;

  cell_word_t cells_due[$];

  logic [2:0]           dim_reg;
  logic [2:0]           len_reg;
  logic [DIST_BITS-1:0] bound_reg [NUM_BOUNDS];
  logic [DIST_BITS-1:0] dist_hist [MAX_MER_LEN];
  logic [DIST_BITS-1:0] dev_hist  [MAX_MER_LEN];
  logic [15:0]          read_pos;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic int digit_of(input int v, input int d);
    int k;
    if (v >= int'(bound_reg[d-2])) begin
      return d - 1;
    end
    for (k = 0; k + 2 < d; k++) begin
      if (int'(bound_reg[k]) >= v) begin
        return k;
      end
    end
    return d - 2;
  endfunction

  // shift the word into the window and queue the cells it produces
  function automatic void bin_distance(input logic [DIST_BITS-1:0] dist_in,
                                       input logic [DIST_BITS-1:0] dev,
                                       input logic rs);
    int d, l, base, n, m, cell_sum, reach, j, i;
    int w [MAX_MER_LEN];
    int dg [MAX_MER_LEN];
    int found [MAX_CELLS];
    cell_word_t cw;
    d = int'(dim_reg);
    if (d < 2) begin
      d = 2;
    end
    if (d > MAX_DIMS) begin
      d = MAX_DIMS;
    end
    l = int'(len_reg);
    if (l < 1) begin
      l = 1;
    end
    if (l > MAX_MER_LEN) begin
      l = MAX_MER_LEN;
    end
    if (rs) begin
      read_pos = '0;
    end
    for (j = 0; j < MAX_MER_LEN - 1; j++) begin
      dist_hist[j] = dist_hist[j+1];
      dev_hist[j] = dev_hist[j+1];
    end
    dist_hist[MAX_MER_LEN-1] = dist_in;
    dev_hist[MAX_MER_LEN-1] = dev;
    if (read_pos != 16'hFFFF) begin
      read_pos = read_pos + 16'd1;
    end
    if (int'(read_pos) < l) begin
      return;
    end
    base = MAX_MER_LEN - l;
    w[l-1] = 1;
    for (j = l - 1; j > 0; j--) begin
      w[j-1] = w[j] * d;
    end
    cell_sum = 0;
    for (j = 0; j < l; j++) begin
      dg[j] = digit_of(int'(dist_hist[base+j]), d);
      cell_sum += dg[j] * w[j];
    end
    found[0] = cell_sum;
    n = 1;
    // each position that reaches past its bound doubles the cell list
    for (j = 0; j < l; j++) begin
      reach = int'(dist_hist[base+j]) + int'(dev_hist[base+j]);
      if (dg[j] + 2 < d && reach > int'(bound_reg[dg[j]])) begin
        m = n;
        for (i = 0; i < m && n < MAX_CELLS; i++) begin
          found[n] = found[i] + w[j];
          n++;
        end
      end
    end
    for (i = 0; i < n; i++) begin
      cw.cell_no = CELL_BITS'(found[i]);
      cw.primary = (i == 0);
      cw.wstart = 16'(int'(read_pos) - l);
      cw.last = (i == n - 1);
      cells_due = {cells_due, cw};
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    cell_word_t want;
    if (rst) begin
      dim_reg = DIM_RESET;
      len_reg = LEN_RESET;
      for (int k = 0; k < NUM_BOUNDS; k++) begin
        bound_reg[k] = '0;
      end
      for (int k = 0; k < MAX_MER_LEN; k++) begin
        dist_hist[k] = '0;
        dev_hist[k] = '0;
      end
      read_pos = '0;
      cells_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (cells_due.size() == 0) begin
          $error("cell word with none expected: cell_index %0d", cell_index);
          mismatches++;
        end else begin
          want = cells_due.pop_front();
          check_field("cell_index", 16'(want.cell_no), 16'(cell_index));
          check_field("is_primary", 16'(want.primary), 16'(is_primary));
          check_field("window_start", want.wstart, window_start);
          check_field("last", 16'(want.last), 16'(last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DIM_COUNT) begin
          dim_reg = cfg_data[2:0];
        end else if (cfg_index == REG_MER_LENGTH) begin
          len_reg = cfg_data[2:0];
        end else if (cfg_index >= REG_BOUND_0 && cfg_index <= REG_BOUND_LAST) begin
          bound_reg[cfg_index - REG_BOUND_0] = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        bin_distance(distance, deviation, read_start);
      end
    end
    outstanding = cells_due.size();
  end

endmodule

[tb/sv/dmer_window_cell_binning_test.sv]
`timescale 1ns / 100ps

module dmer_window_cell_binning_test;
  import dwcb_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 42;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DIST_BITS-1:0] distance = '0;
  logic [DIST_BITS-1:0] deviation = '0;
  logic                 read_start = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CELL_BITS-1:0] cell_index;
  logic                 is_primary;
  logic [15:0]          window_start;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [2:0]           cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  int mismatches;
  int outstanding;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int cycles = 0;
  int read_left = 0;
  logic [DIST_BITS-1:0] cur_bound [NUM_BOUNDS];

  dmer_window_cell_binning dut (.*);

  dmer_window_cell_binning_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req != hold_taken) begin
      hold_taken = hold_req;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_word(input logic [15:0] dist_w, input logic [15:0] dev,
                           input logic rs);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    distance <= dist_w;
    deviation <= dev;
    read_start <= rs;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic configure(input logic [2:0] dims, input logic [2:0] lens,
                           input logic [15:0] b [NUM_BOUNDS]);
    write_reg(REG_DIM_COUNT, {13'($urandom), dims});
    write_reg(REG_MER_LENGTH, {13'($urandom), lens});
    for (int k = 0; k < NUM_BOUNDS; k++) begin
      write_reg(REG_BOUND_0 + 3'(k), b[k]);
      cur_bound[k] = b[k];
    end
    // index past the register list, must be ignored
    write_reg(REG_BOUND_LAST + 3'd1, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed reads with distances near the bounds, some broken starts
  task automatic random_word();
    logic [15:0] dist_w;
    logic [15:0] dev;
    logic        rs;
    int          pick;
    int          v;
    if (read_left == 0) begin
      rs = 1'b1;
      read_left = $urandom_range(1, 24);
    end else begin
      rs = 1'b0;
    end
    read_left--;
    if ($urandom_range(0, 9) == 0) begin
      rs = ~rs;
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      dist_w = 16'd0;
    end else if (pick < 14) begin
      dist_w = 16'hFFFF;
    end else if (pick < 30) begin
      dist_w = 16'($urandom);
    end else begin
      v = int'(cur_bound[$urandom_range(0, NUM_BOUNDS - 1)])
          + int'($urandom_range(0, 40)) - 20;
      if (v < 0) begin
        dist_w = 16'd0;
      end else if (v > 65535) begin
        dist_w = 16'hFFFF;
      end else begin
        dist_w = 16'(v);
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      dev = 16'd0;
    end else if (pick < 14) begin
      dev = 16'hFFFF;
    end else if (pick < 30) begin
      dev = 16'($urandom);
    end else begin
      dev = 16'($urandom_range(0, 40));
    end
    send_word(dist_w, dev, rs);
  endtask

  initial begin
    logic [15:0] b [NUM_BOUNDS];
    logic [2:0]  dims;
    logic [2:0]  lens;
    int          acc;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: all bounds zero, everything lands in the top cell
    send_word(16'd0, 16'd0, 1'b1);
    send_word(16'hFFFF, 16'hFFFF, 1'b0);
    send_word(16'd0, 16'd1, 1'b0);
    settle();

    b = '{16'd100, 16'd200, 16'd300, 16'd400, 16'd500};
    configure(3'd6, 3'd6, b);
    send_word(16'd0, 16'd101, 1'b1);
    send_word(16'd100, 16'd1, 1'b0);
    send_word(16'd101, 16'd200, 1'b0);
    send_word(16'd250, 16'd100, 1'b0);
    send_word(16'd450, 16'd1, 1'b0);
    send_word(16'hFFFF, 16'hFFFF, 1'b0);
    send_word(16'd399, 16'd2, 1'b0);
    // every position reaches its next cell: full neighbour list
    send_word(16'd0, 16'hFFFF, 1'b1);
    send_word(16'd50, 16'hFFFF, 1'b0);
    send_word(16'd150, 16'hFFFF, 1'b0);
    send_word(16'd250, 16'hFFFF, 1'b0);
    send_word(16'd350, 16'hFFFF, 1'b0);
    send_word(16'd100, 16'hFFFF, 1'b0);
    // restart in mid-read
    send_word(16'd300, 16'd5, 1'b1);
    settle();

    b = '{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
    configure(3'd2, 3'd1, b);
    send_word(16'hFFFF, 16'd0, 1'b1);
    send_word(16'hFFFE, 16'd1, 1'b0);
    send_word(16'd0, 16'hFFFF, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          dims = 3'd2;
          lens = 3'd1;
        end
        1: begin
          dims = 3'd6;
          lens = 3'd6;
        end
        2: begin
          dims = 3'd7;
          lens = 3'd0;
        end
        3: begin
          dims = 3'd0;
          lens = 3'd7;
        end
        default: begin
          dims = 3'($urandom_range(0, 7));
          lens = 3'($urandom_range(0, 7));
        end
      endcase
      acc = 0;
      for (int k = 0; k < NUM_BOUNDS; k++) begin
        acc += $urandom_range(0, 13000);
        b[k] = 16'(acc);
        if (ph % 3 == 1) begin
          b[k] = 16'($urandom);
        end
      end
      if (ph % 3 == 2) begin
        b[0] = 16'd0;
        b[NUM_BOUNDS-1] = 16'hFFFF;
      end
      configure(dims, lens, b);
      case (ph % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 53;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 53;
        end
        default: begin
          gap_pct = 19;
          stall_pct = 19;
        end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (ph == 4 && n == 10) begin
          hold_req++;
        end
        random_word();
      end
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
